[hdl/atmn_pkg.sv]
package atmn_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_OFFSET_DEF  = 1024;

  localparam int GAIN_W     = 16;
  localparam int OFFSET_W   = 10;
  localparam int AMP_W      = 23;
  localparam int SEED_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Q4.12 gains, noise kept in units of 2^-30
  localparam int FRAC_BITS   = 12;
  localparam int NOISE_SHIFT = 18;
  localparam int CEN_W       = SEED_W + 1;
  localparam int NZ_W        = AMP_W + 1 + CEN_W;
  localparam int NZH_W       = NZ_W - NOISE_SHIFT;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_A      = 3'd0;
  localparam cfg_idx_t REG_GAIN_B      = 3'd1;
  localparam cfg_idx_t REG_LEAD_SELECT = 3'd2;
  localparam cfg_idx_t REG_OFFSET      = 3'd3;
  localparam cfg_idx_t REG_NOISE_AMP   = 3'd4;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

  localparam logic [SEED_W-1:0]       SEED_RESET   = 31'd1;
  localparam logic [SEED_W-1:0]       LCG_MUL      = 31'd1103515245;
  localparam logic [SEED_W-1:0]       LCG_INC      = 31'd12345;
  localparam logic signed [CEN_W-1:0] NOISE_CENTER = 32'sh4000_0000;
  localparam logic signed [NZ_W-1:0]  ROUND_BIAS   = 56'sh0000_0000_2000_0000;

  typedef struct packed {
    logic accept;
    logic mul;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_stat_t;

endpackage

[hdl/atmn_in_if.sv]
interface atmn_in_if #(
  parameter int SAMPLE_BITS = atmn_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic                          have_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic                          have_b;

  modport source (output valid, output sample_a, output have_a, output sample_b,
                  output have_b, input ready);
  modport sink (input valid, input sample_a, input have_a, input sample_b,
                input have_b, output ready);
endinterface

[hdl/atmn_out_if.sv]
interface atmn_out_if #(
  parameter int SAMPLE_BITS = atmn_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_sample;
  logic                          clipped;

  modport source (output valid, output mixed_sample, output clipped, input ready);
  modport sink (input valid, input mixed_sample, input clipped, output ready);
endinterface

[hdl/atmn_cfg_if.sv]
interface atmn_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [atmn_pkg::CFG_IDX_W-1:0]    index;
  logic [atmn_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/atmn_ram.sv]
module atmn_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hdl/atmn_ctrl.sv]
module atmn_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  atmn_pkg::ctrl_stat_t   stat,
  output atmn_pkg::ctrl_cmd_t    cmd
);
  import atmn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   load;
  logic   accept;

  // the sum stage retires its word in the same cycle a new one may enter
  assign load     = (state == S_SUM) && !stat.out_busy;
  assign in_ready = (state == S_IDLE) || load;
  assign accept   = in_valid && in_ready;

  assign cmd.accept = accept;
  assign cmd.mul    = (state == S_MUL);
  assign cmd.load   = load;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (accept) begin
          state_next = S_MUL;
        end else if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[hdl/atmn_dp.sv]
module atmn_dp #(
  parameter int SAMPLE_BITS = atmn_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_OFFSET  = atmn_pkg::MAX_OFFSET_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  atmn_pkg::ctrl_cmd_t               cmd,
  output atmn_pkg::ctrl_stat_t              stat,
  input  logic                              cfg_we,
  input  atmn_pkg::cfg_idx_t                cfg_index,
  input  logic [atmn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]     sample_a,
  input  logic                              have_a,
  input  logic signed [SAMPLE_BITS-1:0]     sample_b,
  input  logic                              have_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     mixed_sample,
  output logic                              clipped
);
  import atmn_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = $clog2(MAX_OFFSET);
  localparam int CW   = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;
  localparam int PRW  = SB + GAIN_W;
  localparam int W    = (((SB + GAIN_W + 1) > NZH_W) ? (SB + GAIN_W + 1) : NZH_W) + 1;
  localparam int RW   = W - FRAC_BITS;
  localparam int RING_W = SB + 1;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_a;
  logic signed [GAIN_W-1:0] gain_b;
  logic                     lead_select;
  logic [OFFSET_W-1:0]      offset_samples;
  logic [AMP_W-1:0]         noise_amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_a          <= GAIN_RESET;
      gain_b          <= GAIN_RESET;
      lead_select     <= 1'b0;
      offset_samples  <= '0;
      noise_amplitude <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_A:      gain_a          <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_B:      gain_b          <= $signed(cfg_data[GAIN_W-1:0]);
        REG_LEAD_SELECT: lead_select     <= cfg_data[0];
        REG_OFFSET:      offset_samples  <= cfg_data[OFFSET_W-1:0];
        REG_NOISE_AMP:   noise_amplitude <= cfg_data[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ring pointer, wrap flag and noise generator
  logic [PW-1:0]     wp;
  logic              wrapped;
  logic [SEED_W-1:0] seed;
  logic [SEED_W-1:0] seed_next;
  logic              wp_last;

  assign wp_last   = (wp == PW'(MAX_OFFSET - 1));
  assign seed_next = SEED_W'(seed * LCG_MUL + LCG_INC);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      seed    <= SEED_RESET;
    end else if (cmd.accept) begin
      wp <= wp_last ? '0 : wp + 1'b1;
      if (wp_last) begin
        wrapped <= 1'b1;
      end
      if (noise_amplitude != '0) begin
        seed <= seed_next;
      end
    end
  end

  // read position, offset clamped to one below the ring depth
  logic [CW-1:0] off_ext;
  logic [CW-1:0] d_ext;
  logic [CW-1:0] wp_ext;
  logic [CW-1:0] rp_ext;
  logic [PW-1:0] rp;
  logic          bypass;
  logic          rd_written;

  assign off_ext    = CW'(offset_samples);
  assign d_ext      = (off_ext > CW'(MAX_OFFSET - 1)) ? CW'(MAX_OFFSET - 1) : off_ext;
  assign wp_ext     = CW'(wp);
  assign rp_ext     = (wp_ext >= d_ext) ? (wp_ext - d_ext)
                                        : (wp_ext + CW'(MAX_OFFSET) - d_ext);
  assign rp         = rp_ext[PW-1:0];
  assign bypass     = (d_ext == '0);
  // before the first wrap only slots below the write pointer hold data
  assign rd_written = wrapped || (wp_ext >= d_ext);

  logic signed [SB-1:0] late_v;
  logic                 late_h;
  logic [RING_W-1:0]    ring_rd;

  assign late_v = lead_select ? sample_a : sample_b;
  assign late_h = lead_select ? have_a : have_b;

  atmn_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_OFFSET)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wp),
    .wdata ({late_h, late_v}),
    .re    (cmd.accept),
    .raddr (rp),
    .rdata (ring_rd)
  );

  // input stage
  logic signed [SB-1:0] a_q;
  logic signed [SB-1:0] b_q;
  logic                 ha_q;
  logic                 hb_q;
  logic                 bypass_q;
  logic                 rdw_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_q      <= sample_a;
      b_q      <= sample_b;
      ha_q     <= have_a;
      hb_q     <= have_b;
      bypass_q <= bypass;
      rdw_q    <= rd_written;
    end
  end

  // multiply stage
  logic signed [SB-1:0]    dly_v;
  logic                    dly_h;
  logic signed [SB-1:0]    a_eff;
  logic signed [SB-1:0]    b_eff;
  logic                    ha_eff;
  logic                    hb_eff;
  logic signed [PRW-1:0]   pa;
  logic signed [PRW-1:0]   pb;
  logic signed [AMP_W:0]   amp_s;
  logic signed [CEN_W-1:0] cen;
  logic signed [NZ_W-1:0]  nz;
  logic signed [PRW-1:0]   pa_q;
  logic signed [PRW-1:0]   pb_q;
  logic signed [NZ_W-1:0]  nz_q;

  assign dly_v  = lead_select ? (bypass_q ? a_q : $signed(ring_rd[SB-1:0]))
                              : (bypass_q ? b_q : $signed(ring_rd[SB-1:0]));
  assign dly_h  = bypass_q ? (lead_select ? ha_q : hb_q) : (ring_rd[SB] && rdw_q);
  assign a_eff  = lead_select ? dly_v : a_q;
  assign ha_eff = lead_select ? dly_h : ha_q;
  assign b_eff  = lead_select ? b_q : dly_v;
  assign hb_eff = lead_select ? hb_q : dly_h;

  // both arms signed so the product is sign extended
  assign pa    = ha_eff ? gain_a * a_eff : $signed({PRW{1'b0}});
  assign pb    = hb_eff ? gain_b * b_eff : $signed({PRW{1'b0}});
  assign amp_s = $signed({1'b0, noise_amplitude});
  assign cen   = $signed({1'b0, seed}) - NOISE_CENTER;
  assign nz    = amp_s * cen;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_q <= pa;
      pb_q <= pb;
      nz_q <= nz;
    end
  end

  // sum, round half up and saturate
  logic signed [NZ_W-1:0]  nzr;
  logic signed [NZH_W-1:0] nzh;
  logic signed [W-1:0]     sum;
  logic signed [RW-1:0]    res;
  logic                    fits;
  logic signed [SB-1:0]    sat_val;

  assign nzr     = nz_q + ROUND_BIAS;
  assign nzh     = $signed(nzr[NZ_W-1:NOISE_SHIFT]);
  assign sum     = W'(pa_q) + W'(pb_q) + W'(nzh);
  assign res     = $signed(sum[W-1:FRAC_BITS]);
  assign fits    = (&res[RW-1:SB-1]) || !(|res[RW-1:SB-1]);
  assign sat_val = res[RW-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                             : $signed({1'b0, {(SB-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mixed_sample <= fits ? res[SB-1:0] : sat_val;
      clipped      <= !fits;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;
endmodule

[hdl/aligned_trace_mixer_with_noise.sv]
// Two-trace mixer with alignment delay and optional uniform noise.
// feed:   one word carries the next sample of trace A and of trace B, each
//         with a present flag; a word is taken when valid and ready are high.
// result: one word per feed word, the mixed sample and a clip flag, in order.
// cfg:    register writes (gain_a, gain_b, lead_select, offset_samples,
//         noise_amplitude by index 0..4); always ready, write only when idle.
// The later trace passes through a ring of MAX_OFFSET entries and is read
// offset_samples behind the write pointer.
// A taken word passes the ring read and input registers, then the multiply
// stage, then the sum/round/saturate stage into the output register.
// The next word is taken only once the last has left the multiply stage and
// the output can take it; feed drops ready during the multiply.
// If result stalls, one finished word waits in the output register, one more
// word may be taken and then feed holds ready low until the output drains.
// Reset clears the pointer, the noise seed (to one) and the registers; ring
// slots not yet written since reset read as absent, no clearing pass.
module aligned_trace_mixer_with_noise #(
  parameter int SAMPLE_BITS = atmn_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_OFFSET  = atmn_pkg::MAX_OFFSET_DEF
) (
  input logic       clk,
  input logic       rst,
  atmn_in_if.sink   feed,
  atmn_out_if.source result,
  atmn_cfg_if.sink  cfg
);
  import atmn_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;

  assign feed.ready = in_ready;
  assign cfg.ready  = 1'b1;

  atmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atmn_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_OFFSET  (MAX_OFFSET)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .sample_a     (feed.sample_a),
    .have_a       (feed.have_a),
    .sample_b     (feed.sample_b),
    .have_b       (feed.have_b),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .mixed_sample (result.mixed_sample),
    .clipped      (result.clipped)
  );
endmodule

[hdl/atmn_chk.sv]
module atmn_chk #(
  parameter int SAMPLE_BITS = atmn_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] mixed_sample,
  input logic                   clipped
);
  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(mixed_sample) && $stable(clipped))
    else $error("result payload changed while stalled");

  // the multiply stage blocks feed in the cycle after every accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("feed ready right after an accepted word");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind aligned_trace_mixer_with_noise atmn_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_atmn_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (feed.valid),
  .in_ready     (feed.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .mixed_sample (result.mixed_sample),
  .clipped      (result.clipped)
);
